>>> hdl/tcw_pkg.sv
// tcw_pkg: shared constants, codes and controller/datapath types for the
// text console writer. No dependencies.

package tcw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int TAB_SPACES    = 4;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

  // field widths fixed by the stream payload
  localparam int ADDR_W = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int TAB_W  = $clog2(TAB_SPACES + 1);

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CELL_W-1:0] BLANK_RESET  = 16'h0720;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_DELETE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_SETPOS = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_GLYPH,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_FILL_RESET,
    DP_LOAD,
    DP_NEWLINE,
    DP_TAB_START,
    DP_GLYPH,
    DP_DELETE,
    DP_CLEAR_START,
    DP_CLEAR,
    DP_SETPOS,
    DP_READ_ISSUE,
    DP_READ_TAKE,
    DP_SCROLL_START,
    DP_SCROLL_COPY,
    DP_SCROLL_BLANK
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       is_newline;
    logic       is_tab;
    logic       at_origin;
    logic       row_last;
    logic       col_last;
    logic       cidx_ok;
    logic       copy_done;
    logic       sweep_end;
    logic       tab_last;
    logic       tab_more;
    logic       out_free;
  } dp_sts_t;

endpackage

>>> hdl/tcw_ctrl.sv
// tcw_ctrl: command sequencer of the text console writer.
// Depends on tcw_pkg; drives tcw_dp through dp_cmd_t, reads dp_sts_t.

module tcw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tcw_pkg::dp_sts_t sts_i,
  output tcw_pkg::dp_cmd_t cmd_o
);

  tcw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        if (sts_i.sweep_end) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        case (sts_i.opcode)
          tcw_pkg::OP_WRITE: begin
            if (sts_i.is_newline) begin
              state_d = sts_i.row_last ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
            end else begin
              state_d = tcw_pkg::ST_GLYPH;
            end
          end
          tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_CLEAR;
          tcw_pkg::OP_READ:  state_d = sts_i.cidx_ok ? tcw_pkg::ST_READ : tcw_pkg::ST_DONE;
          default:           state_d = tcw_pkg::ST_DONE;
        endcase
      end
      tcw_pkg::ST_GLYPH: begin
        if (sts_i.col_last && sts_i.row_last) begin
          state_d = tcw_pkg::ST_SCROLL;
        end else if (sts_i.tab_last) begin
          state_d = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (sts_i.copy_done) state_d = tcw_pkg::ST_BLANK;
      end
      tcw_pkg::ST_BLANK: begin
        if (sts_i.sweep_end) begin
          state_d = sts_i.tab_more ? tcw_pkg::ST_GLYPH : tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        if (sts_i.sweep_end) state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_READ: state_d = tcw_pkg::ST_DONE;
      tcw_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op       = tcw_pkg::DP_NOP;
    cmd_o.out_load = 1'b0;
    in_ready_o     = 1'b0;
    case (state_q)
      tcw_pkg::ST_INIT: cmd_o.op = tcw_pkg::DP_FILL_RESET;
      tcw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = tcw_pkg::DP_LOAD;
      end
      tcw_pkg::ST_EXEC: begin
        case (sts_i.opcode)
          tcw_pkg::OP_WRITE: begin
            if (sts_i.is_newline) begin
              cmd_o.op = sts_i.row_last ? tcw_pkg::DP_SCROLL_START : tcw_pkg::DP_NEWLINE;
            end else begin
              cmd_o.op = tcw_pkg::DP_TAB_START;
            end
          end
          tcw_pkg::OP_DELETE: begin
            if (!sts_i.at_origin) cmd_o.op = tcw_pkg::DP_DELETE;
          end
          tcw_pkg::OP_CLEAR:  cmd_o.op = tcw_pkg::DP_CLEAR_START;
          tcw_pkg::OP_SETPOS: cmd_o.op = tcw_pkg::DP_SETPOS;
          tcw_pkg::OP_READ: begin
            if (sts_i.cidx_ok) cmd_o.op = tcw_pkg::DP_READ_ISSUE;
          end
          default: cmd_o.op = tcw_pkg::DP_NOP;
        endcase
      end
      tcw_pkg::ST_GLYPH:  cmd_o.op = tcw_pkg::DP_GLYPH;
      tcw_pkg::ST_SCROLL: cmd_o.op = tcw_pkg::DP_SCROLL_COPY;
      tcw_pkg::ST_BLANK:  cmd_o.op = tcw_pkg::DP_SCROLL_BLANK;
      tcw_pkg::ST_CLEAR:  cmd_o.op = tcw_pkg::DP_CLEAR;
      tcw_pkg::ST_READ:   cmd_o.op = tcw_pkg::DP_READ_TAKE;
      tcw_pkg::ST_DONE:   cmd_o.out_load = sts_i.out_free;
      default:            cmd_o.op = tcw_pkg::DP_NOP;
    endcase
  end

endmodule

>>> hdl/tcw_dp.sv
// tcw_dp: screen memory, cursor, sweep counter and result register of the
// text console writer. Depends on tcw_pkg; controlled by tcw_ctrl.

module tcw_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcw_pkg::dp_cmd_t              cmd_i,
  output tcw_pkg::dp_sts_t              sts_o,
  input  logic [3:0]                    fore_i,
  input  logic [3:0]                    back_i,
  input  logic [2:0]                    opcode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::ROW_W-1:0]     new_row_i,
  input  logic [tcw_pkg::COL_W-1:0]     new_col_i,
  input  logic [tcw_pkg::ADDR_W-1:0]    cell_index_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tcw_pkg::CELL_W-1:0]    read_word_o,
  output logic [tcw_pkg::ADDR_W-1:0]    cursor_index_o,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]     cursor_col_o,
  output logic                          did_scroll_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam logic [AW-1:0] LAST_CELL  = AW'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [AW-1:0] COPY_END   = AW'(tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_WIDTH);
  localparam logic [AW-1:0] WIDTH_A    = AW'(tcw_pkg::SCREEN_WIDTH);
  localparam logic [tcw_pkg::ROW_W-1:0] ROW_MAX = tcw_pkg::ROW_W'(tcw_pkg::SCREEN_HEIGHT - 1);
  localparam logic [tcw_pkg::COL_W-1:0] COL_MAX = tcw_pkg::COL_W'(tcw_pkg::SCREEN_WIDTH - 1);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  // latched command
  logic [2:0]                 opc_q;
  logic [tcw_pkg::CHAR_W-1:0] ch_q, glyph_q;
  logic [tcw_pkg::ROW_W-1:0]  nrow_q;
  logic [tcw_pkg::COL_W-1:0]  ncol_q;
  logic [AW-1:0]              cidx_q;

  logic [tcw_pkg::ROW_W-1:0]  row_q, row_d;
  logic [tcw_pkg::COL_W-1:0]  col_q, col_d;
  logic [AW-1:0]              sweep_q, sweep_d;
  logic [tcw_pkg::TAB_W-1:0]  tab_q, tab_d;
  logic                       scroll_q, scroll_d;
  logic [tcw_pkg::CELL_W-1:0] word_q;
  logic                       out_valid_q;

  logic [AW-1:0]              cur_idx;
  logic [7:0]                 attr;
  logic [tcw_pkg::CELL_W-1:0] blank;
  logic                       we, re;
  logic [AW-1:0]              waddr, raddr;
  logic [tcw_pkg::CELL_W-1:0] wdata;

  assign attr    = {back_i, fore_i};
  assign blank   = {attr, tcw_pkg::CHAR_SPACE};
  assign cur_idx = AW'(int'(row_q) * tcw_pkg::SCREEN_WIDTH + int'(col_q));

  assign sts_o.opcode     = opc_q;
  assign sts_o.is_newline = (ch_q == tcw_pkg::CHAR_NEWLINE);
  assign sts_o.is_tab     = (ch_q == tcw_pkg::CHAR_TAB);
  assign sts_o.at_origin  = (row_q == '0) && (col_q == '0);
  assign sts_o.row_last   = (row_q == ROW_MAX);
  assign sts_o.col_last   = (col_q == COL_MAX);
  assign sts_o.cidx_ok    = (cidx_q <= LAST_CELL);
  assign sts_o.copy_done  = (sweep_q == COPY_END);
  assign sts_o.sweep_end  = (sweep_q == LAST_CELL);
  assign sts_o.tab_last   = (tab_q == tcw_pkg::TAB_W'(1));
  assign sts_o.tab_more   = (tab_q != '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // memory port selection
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = sweep_q;
    raddr = cidx_q;
    wdata = blank;
    case (cmd_i.op)
      tcw_pkg::DP_FILL_RESET: begin
        we    = 1'b1;
        wdata = tcw_pkg::BLANK_RESET;
      end
      tcw_pkg::DP_GLYPH: begin
        we    = 1'b1;
        waddr = cur_idx;
        wdata = {attr, glyph_q};
      end
      tcw_pkg::DP_DELETE: begin
        // one cell back, also across a row boundary
        we    = 1'b1;
        waddr = cur_idx - AW'(1);
      end
      tcw_pkg::DP_SCROLL_COPY: begin
        // read one row ahead, write the previous read in the next cycle
        re    = !sts_o.copy_done;
        raddr = sweep_q + WIDTH_A;
        we    = (sweep_q != '0);
        waddr = sweep_q - AW'(1);
        wdata = rdata_q;
      end
      tcw_pkg::DP_SCROLL_BLANK, tcw_pkg::DP_CLEAR: we = 1'b1;
      tcw_pkg::DP_READ_ISSUE: re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // cursor, sweep and tab sequencing
  always_comb begin
    row_d    = row_q;
    col_d    = col_q;
    sweep_d  = sweep_q;
    tab_d    = tab_q;
    scroll_d = scroll_q;
    case (cmd_i.op)
      tcw_pkg::DP_FILL_RESET: sweep_d = sts_o.sweep_end ? '0 : sweep_q + AW'(1);
      tcw_pkg::DP_LOAD:       scroll_d = 1'b0;
      tcw_pkg::DP_NEWLINE: begin
        row_d = row_q + tcw_pkg::ROW_W'(1);
        col_d = '0;
      end
      tcw_pkg::DP_TAB_START: begin
        tab_d = sts_o.is_tab ? tcw_pkg::TAB_W'(tcw_pkg::TAB_SPACES) : tcw_pkg::TAB_W'(1);
      end
      tcw_pkg::DP_GLYPH: begin
        tab_d = tab_q - tcw_pkg::TAB_W'(1);
        if (sts_o.col_last) begin
          col_d = '0;
          if (sts_o.row_last) begin
            scroll_d = 1'b1;
            sweep_d  = '0;
          end else begin
            row_d = row_q + tcw_pkg::ROW_W'(1);
          end
        end else begin
          col_d = col_q + tcw_pkg::COL_W'(1);
        end
      end
      tcw_pkg::DP_DELETE: begin
        if (col_q == '0) begin
          row_d = row_q - tcw_pkg::ROW_W'(1);
          col_d = COL_MAX;
        end else begin
          col_d = col_q - tcw_pkg::COL_W'(1);
        end
      end
      tcw_pkg::DP_CLEAR_START: begin
        row_d   = '0;
        col_d   = '0;
        sweep_d = '0;
      end
      tcw_pkg::DP_SETPOS: begin
        row_d = (nrow_q > ROW_MAX) ? ROW_MAX : nrow_q;
        col_d = (ncol_q > COL_MAX) ? COL_MAX : ncol_q;
      end
      tcw_pkg::DP_SCROLL_START: begin
        row_d    = ROW_MAX;
        col_d    = '0;
        sweep_d  = '0;
        tab_d    = '0;
        scroll_d = 1'b1;
      end
      tcw_pkg::DP_SCROLL_COPY: sweep_d = sts_o.copy_done ? sweep_q : sweep_q + AW'(1);
      tcw_pkg::DP_SCROLL_BLANK, tcw_pkg::DP_CLEAR: sweep_d = sweep_q + AW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      sweep_q     <= '0;
      tab_q       <= '0;
      scroll_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q    <= row_d;
      col_q    <= col_d;
      sweep_q  <= sweep_d;
      tab_q    <= tab_d;
      scroll_q <= scroll_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tcw_pkg::DP_LOAD) begin
      opc_q  <= opcode_i;
      ch_q   <= char_code_i;
      nrow_q <= new_row_i;
      ncol_q <= new_col_i;
      cidx_q <= cell_index_i;
      word_q <= '0;
    end
    if (cmd_i.op == tcw_pkg::DP_TAB_START) begin
      glyph_q <= sts_o.is_tab ? tcw_pkg::CHAR_SPACE : ch_q;
    end
    if (cmd_i.op == tcw_pkg::DP_READ_TAKE) begin
      word_q <= rdata_q;
    end
    if (cmd_i.out_load) begin
      read_word_o    <= word_q;
      cursor_index_o <= cur_idx;
      cursor_row_o   <= row_q;
      cursor_col_o   <= col_q;
      did_scroll_o   <= scroll_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/text_console_writer.sv
// text_console_writer: top level with stream ports, APB color registers,
// sequencer (tcw_ctrl) and datapath (tcw_dp). Depends on tcw_pkg.
//
// Text console engine: 80x25 screen of 16-bit cells (attribute high byte,
// character low byte) and a cursor; one request in gives one result out.
// After reset the screen memory is filled with grey spaces, during which no
// request is taken (color registers are writable). Work goes through the
// single-write, single-read screen memory and the command sequencer: a tab
// writes four spaces, a scroll copies 1920 cells up a row and then blanks the
// 80-cell bottom row, one cell per cycle, and clear blanks the whole screen.
// A result waits in an output register while the next request is taken.

module text_console_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request: [7:0] char_code, [12:8] new_row, [19:13] new_col,
  //          [30:20] cell_index, [31] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
  // result: [15:0] read_word, [26:16] cursor_index, [31:27] cursor_row,
  //         [38:32] cursor_col, [39] did_scroll
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  // color registers: 0x0 fore_colour, 0x4 back_colour
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tcw_pkg::dp_cmd_t cmd;
  tcw_pkg::dp_sts_t sts;

  logic [3:0] fore_q, back_q;
  logic       cfg_wr;

  logic [tcw_pkg::CELL_W-1:0] read_word;
  logic [tcw_pkg::ADDR_W-1:0] cursor_index;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::COL_W-1:0]  cursor_col;
  logic                       did_scroll;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q <= 4'd7;
      back_q <= 4'd0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        back_q <= pwdata[3:0];
      end else begin
        fore_q <= pwdata[3:0];
      end
    end
  end

  assign prdata = paddr[2] ? {28'd0, back_q} : {28'd0, fore_q};

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .fore_i         (fore_q),
    .back_i         (back_q),
    .opcode_i       (s_axis_tuser),
    .char_code_i    (s_axis_tdata[7:0]),
    .new_row_i      (s_axis_tdata[12:8]),
    .new_col_i      (s_axis_tdata[19:13]),
    .cell_index_i   (s_axis_tdata[30:20]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .read_word_o    (read_word),
    .cursor_index_o (cursor_index),
    .cursor_row_o   (cursor_row),
    .cursor_col_o   (cursor_col),
    .did_scroll_o   (did_scroll)
  );

  assign m_axis_tdata = {did_scroll, cursor_col, cursor_row, cursor_index, read_word};

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(cursor_row) < tcw_pkg::SCREEN_HEIGHT) &&
                      (int'(cursor_col) < tcw_pkg::SCREEN_WIDTH))
    else $error("cursor out of screen");

  a_index_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> int'(cursor_index) ==
                      int'(cursor_row) * tcw_pkg::SCREEN_WIDTH + int'(cursor_col))
    else $error("cursor index does not match row and column");

  a_scroll_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && did_scroll) |->
      int'(cursor_row) == tcw_pkg::SCREEN_HEIGHT - 1)
    else $error("scroll left cursor off the bottom row");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in work");
`endif

endmodule
